[rtl/cch_pkg.sv]
// ----------------------------------------------------------------------------
// cch_pkg
// Shared types, widths and constants of the calibrated compass heading core.
// ----------------------------------------------------------------------------
package cch_pkg;

    localparam int RAW_W      = 16;              // raw counts and register width
    localparam int DIFF_W     = RAW_W + 1;       // offset-corrected axis
    localparam int PROD_W     = RAW_W + DIFF_W;  // coefficient times axis
    localparam int SUM_W      = PROD_W + 2;      // sum of three products
    localparam int MAG_W      = SUM_W - 1;       // magnitude of a sum
    localparam int SHIFT_W    = 6;
    localparam int NORM_MSB   = 40;              // larger magnitude lands in [2^40, 2^41)
    localparam int CV_W       = 45;              // CORDIC x/y datapath
    localparam int ANG_W      = 25;              // CORDIC angle, Q16 degrees
    localparam int ACC_W      = 27;              // angle plus half-plane offset
    localparam int ANG_FRAC   = 16;
    localparam int DEG_W      = 10;
    localparam int HEADING_W  = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int TABLE_LEN  = 24;
    localparam int CORDIC_STEPS = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;

    localparam logic signed [ACC_W-1:0] ANG_180 = ACC_W'(180 * 65536);
    localparam logic signed [ACC_W-1:0] ANG_360 = ACC_W'(360 * 65536);

    localparam logic [HEADING_W-1:0] HD_0   = HEADING_W'(0);
    localparam logic [HEADING_W-1:0] HD_90  = HEADING_W'(90);
    localparam logic [HEADING_W-1:0] HD_180 = HEADING_W'(180);
    localparam logic [HEADING_W-1:0] HD_270 = HEADING_W'(270);
    localparam logic [DEG_W-1:0]     DEG_360 = DEG_W'(360);

    // atan(2^-i) in degrees, Q16, rounded to nearest
    localparam int ATAN_DEG_Q16 [TABLE_LEN] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_X = 3'd0,
        REG_OFFSET_Y = 3'd1,
        REG_OFFSET_Z = 3'd2,
        REG_SOFT_XX  = 3'd3,
        REG_SOFT_XY  = 3'd4,
        REG_SOFT_XZ  = 3'd5,
        REG_SOFT_YY  = 3'd6,
        REG_SOFT_YZ  = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [RAW_W-1:0] offset_x;
        logic signed [RAW_W-1:0] offset_y;
        logic signed [RAW_W-1:0] offset_z;
        logic signed [RAW_W-1:0] soft_xx;
        logic signed [RAW_W-1:0] soft_xy;
        logic signed [RAW_W-1:0] soft_xz;
        logic signed [RAW_W-1:0] soft_yy;
        logic signed [RAW_W-1:0] soft_yz;
    } cfg_t;

    // corrected horizontal vector, common scale 2^14
    typedef struct packed {
        logic signed [SUM_W-1:0] xc;
        logic signed [SUM_W-1:0] yc;
    } vec_t;

    // per-item classification carried alongside the CORDIC
    typedef struct packed {
        logic                 special;
        logic [HEADING_W-1:0] spec_hd;
        logic                 left;
        logic                 up;
    } side_t;

endpackage

[rtl/calibrated_compass_heading_core.sv]
// ----------------------------------------------------------------------------
// calibrated_compass_heading_core
// Magnetometer sample to calibrated whole-degree compass heading.
// ----------------------------------------------------------------------------
// One raw x/y/z sample enters per beat and one heading (0..359, atan2 of the
// calibrated horizontal vector plus 180, truncated) leaves per beat. The
// block sustains one sample per clock while m_tready is held high. A sample
// passes the offset/matrix front, a four-entry queue and the back end
// (classify, leading-one search, normalizing shift, 16 CORDIC stages, two
// degree stages) in that order. Calibration registers reset to the factory
// values and must only be written while no sample is in flight.
module calibrated_compass_heading_core
    import cch_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [RAW_W-1:0]     cfg_data,
    // sample input
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [3*RAW_W-1:0]   s_tdata,   // mag_x[15:0], mag_y[31:16], mag_z[47:32]
    // heading output
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata    // heading_deg[8:0], zero [15:9]
);

    cfg_t                 cfg_reg;
    logic                 fq_valid, fq_ready, qb_valid, qb_ready;
    vec_t                 fq_item, qb_item;
    logic [HEADING_W-1:0] heading;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_x <= RAW_W'(101);
            cfg_reg.offset_y <= RAW_W'(249);
            cfg_reg.offset_z <= -RAW_W'(118);
            cfg_reg.soft_xx  <= RAW_W'(15852);
            cfg_reg.soft_xy  <= -RAW_W'(1227);
            cfg_reg.soft_xz  <= -RAW_W'(630);
            cfg_reg.soft_yy  <= RAW_W'(15817);
            cfg_reg.soft_yz  <= -RAW_W'(1150);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_OFFSET_X: cfg_reg.offset_x <= cfg_data;
                REG_OFFSET_Y: cfg_reg.offset_y <= cfg_data;
                REG_OFFSET_Z: cfg_reg.offset_z <= cfg_data;
                REG_SOFT_XX:  cfg_reg.soft_xx  <= cfg_data;
                REG_SOFT_XY:  cfg_reg.soft_xy  <= cfg_data;
                REG_SOFT_XZ:  cfg_reg.soft_xz  <= cfg_data;
                REG_SOFT_YY:  cfg_reg.soft_yy  <= cfg_data;
                REG_SOFT_YZ:  cfg_reg.soft_yz  <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    cch_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .mag_x     (s_tdata[RAW_W-1:0]),
        .mag_y     (s_tdata[2*RAW_W-1:RAW_W]),
        .mag_z     (s_tdata[3*RAW_W-1:2*RAW_W]),
        .out_valid (fq_valid),
        .out_ready (fq_ready),
        .out_item  (fq_item)
    );

    cch_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    cch_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_item   (qb_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .heading   (heading)
    );

    assign m_tdata = {(16-HEADING_W)'(0), heading};

endmodule

[rtl/cch_front.sv]
// ----------------------------------------------------------------------------
// cch_front
// Hard-iron offset removal and soft-iron matrix rows, three pipeline stages.
// ----------------------------------------------------------------------------
module cch_front
    import cch_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [RAW_W-1:0] mag_x,
    input  logic signed [RAW_W-1:0] mag_y,
    input  logic signed [RAW_W-1:0] mag_z,
    output logic                    out_valid,
    input  logic                    out_ready,
    output vec_t                    out_item
);

    logic [2:0] vld_reg;
    logic       adv;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [DIFF_W-1:0] dx_next, dy_next, dz_next;

    logic signed [PROD_W-1:0] pxx_reg, pxy_reg, pxz_reg, pyx_reg, pyy_reg, pyz_reg;
    logic signed [PROD_W-1:0] pxx_next, pxy_next, pxz_next, pyx_next, pyy_next, pyz_next;

    vec_t vec_reg, vec_next;

    assign adv       = !vld_reg[2] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[2];
    assign out_item  = vec_reg;

    always_comb
    begin
        dx_next = DIFF_W'(mag_x) - DIFF_W'(cfg.offset_x);
        dy_next = DIFF_W'(mag_y) - DIFF_W'(cfg.offset_y);
        dz_next = DIFF_W'(mag_z) - DIFF_W'(cfg.offset_z);

        pxx_next = PROD_W'(cfg.soft_xx) * PROD_W'(dx_reg);
        pxy_next = PROD_W'(cfg.soft_xy) * PROD_W'(dy_reg);
        pxz_next = PROD_W'(cfg.soft_xz) * PROD_W'(dz_reg);
        pyx_next = PROD_W'(cfg.soft_xy) * PROD_W'(dx_reg);
        pyy_next = PROD_W'(cfg.soft_yy) * PROD_W'(dy_reg);
        pyz_next = PROD_W'(cfg.soft_yz) * PROD_W'(dz_reg);

        vec_next.xc = SUM_W'(pxx_reg) + SUM_W'(pxy_reg) + SUM_W'(pxz_reg);
        vec_next.yc = SUM_W'(pyx_reg) + SUM_W'(pyy_reg) + SUM_W'(pyz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            dz_reg  <= dz_next;
            pxx_reg <= pxx_next;
            pxy_reg <= pxy_next;
            pxz_reg <= pxz_next;
            pyx_reg <= pyx_next;
            pyy_reg <= pyy_next;
            pyz_reg <= pyz_next;
            vec_reg <= vec_next;
        end
    end

endmodule

[rtl/cch_queue.sv]
// ----------------------------------------------------------------------------
// cch_queue
// Short first-in first-out buffer of corrected vectors between front and back.
// ----------------------------------------------------------------------------
module cch_queue
    import cch_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  vec_t in_item,
    output logic out_valid,
    input  logic out_ready,
    output vec_t out_item
);

    vec_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/cch_back.sv]
// ----------------------------------------------------------------------------
// cch_back
// Classify, normalize, unrolled vectoring CORDIC and degree conversion.
// ----------------------------------------------------------------------------
module cch_back
    import cch_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vec_t                 in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [HEADING_W-1:0] heading
);

    localparam int NST    = CORDIC_STEPS + 5;     // classify, lzc, shift, CORDIC, add, wrap
    localparam int ST_ADD = CORDIC_STEPS + 3;

    logic           vld_reg  [NST];
    side_t          side_reg [NST-1];
    side_t          side_next;
    logic           adv;

    // classify stage
    logic signed [SUM_W-1:0] x0_reg, y0_reg, x0_next, y0_next;
    // leading-one stage
    logic signed [SUM_W-1:0] x1_reg, y1_reg;
    logic [SHIFT_W-1:0]      sh1_reg, sh1_next;
    logic [MAG_W-1:0]        mag_or;
    logic [SHIFT_W-1:0]      msb;
    // CORDIC
    logic signed [CV_W-1:0]  cx_reg [CORDIC_STEPS+1];
    logic signed [CV_W-1:0]  cy_reg [CORDIC_STEPS+1];
    logic signed [ANG_W-1:0] cz_reg [CORDIC_STEPS+1];
    // degree conversion
    logic signed [ACC_W-1:0] acc_reg, acc_next, acc_wrap;
    logic [DEG_W-1:0]        deg;
    logic [HEADING_W-1:0]    heading_reg, heading_next;

    assign adv       = !vld_reg[NST-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[NST-1];
    assign heading   = heading_reg;

    // classify: axis and zero cases, fold left half plane onto the right
    always_comb
    begin
        side_next.left    = in_item.xc < 0;
        side_next.up      = in_item.yc > 0;
        side_next.special = (in_item.xc == '0) || (in_item.yc == '0);
        if (in_item.yc == '0)
        begin
            side_next.spec_hd = (in_item.xc < 0) ? HD_0 : HD_180;
        end
        else
        begin
            side_next.spec_hd = (in_item.yc > 0) ? HD_270 : HD_90;
        end
        x0_next = side_next.left ? -in_item.xc : in_item.xc;
        y0_next = side_next.left ? -in_item.yc : in_item.yc;
    end

    // position of the leading one of the larger magnitude
    always_comb
    begin
        mag_or = MAG_W'(x0_reg) | MAG_W'(y0_reg[SUM_W-1] ? -y0_reg : y0_reg);
        msb    = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (mag_or[i])
            begin
                msb = SHIFT_W'(i);
            end
        end
        sh1_next = SHIFT_W'(NORM_MSB) - msb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < NST-1; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            x0_reg    <= x0_next;
            y0_reg    <= y0_next;
            x1_reg    <= x0_reg;
            y1_reg    <= y0_reg;
            sh1_reg   <= sh1_next;
            cx_reg[0] <= CV_W'(x1_reg) <<< sh1_reg;
            cy_reg[0] <= CV_W'(y1_reg) <<< sh1_reg;
            cz_reg[0] <= '0;
        end
    end

    // one micro-rotation per stage, shifts floor toward minus infinity
    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_cordic
        logic signed [CV_W-1:0]  xs, ys, x_next, y_next;
        logic signed [ANG_W-1:0] z_next;

        always_comb
        begin
            xs = cx_reg[k] >>> k;
            ys = cy_reg[k] >>> k;
            if (cy_reg[k] > 0)
            begin
                x_next = cx_reg[k] + ys;
                y_next = cy_reg[k] - xs;
                z_next = cz_reg[k] + ANG_W'(ATAN_DEG_Q16[k]);
            end
            else
            begin
                x_next = cx_reg[k] - ys;
                y_next = cy_reg[k] + xs;
                z_next = cz_reg[k] - ANG_W'(ATAN_DEG_Q16[k]);
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cx_reg[k+1] <= x_next;
                cy_reg[k+1] <= y_next;
                cz_reg[k+1] <= z_next;
            end
        end
    end

    // add half-plane offset, then wrap and floor to whole degrees; axis/zero use spec_hd
    always_comb
    begin
        acc_next = ACC_W'(cz_reg[CORDIC_STEPS]);
        if (!side_reg[ST_ADD-1].left)
        begin
            acc_next = acc_next + ANG_180;
        end
        else if (side_reg[ST_ADD-1].up)
        begin
            acc_next = acc_next + ANG_360;
        end

        acc_wrap = (acc_reg < 0) ? acc_reg + ANG_360 : acc_reg;
        deg      = acc_wrap[ANG_FRAC +: DEG_W];
        if (deg >= DEG_360)
        begin
            deg = deg - DEG_360;
        end

        if (side_reg[ST_ADD].special)
        begin
            heading_next = side_reg[ST_ADD].spec_hd;
        end
        else
        begin
            heading_next = deg[HEADING_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg     <= acc_next;
            heading_reg <= heading_next;
        end
    end

endmodule
